FILE: rtl/core/qmc_pkg.sv
// package: shared constants, opcodes, command and status types for the queue machine
`default_nettype none
package qmc_pkg;
  localparam int QueueDepth = 4096;
  localparam int QAW = $clog2(QueueDepth);
  localparam int QCW = $clog2(QueueDepth + 1);
  localparam int ProgramDepth = 4096;
  localparam int PCW = 13;
  localparam int RegCount = 26;
  localparam int WordW = 16;

  localparam logic [4:0] OP_PUSH  = 5'd0;
  localparam logic [4:0] OP_ADD   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_MUL   = 5'd3;
  localparam logic [4:0] OP_DIV   = 5'd4;
  localparam logic [4:0] OP_MOD   = 5'd5;
  localparam logic [4:0] OP_POPR  = 5'd6;
  localparam logic [4:0] OP_PUSHR = 5'd7;
  localparam logic [4:0] OP_PRNP  = 5'd8;
  localparam logic [4:0] OP_PRNR  = 5'd9;
  localparam logic [4:0] OP_CHRP  = 5'd10;
  localparam logic [4:0] OP_CHRR  = 5'd11;
  localparam logic [4:0] OP_JMP   = 5'd13;
  localparam logic [4:0] OP_JZ    = 5'd14;
  localparam logic [4:0] OP_JEQ   = 5'd15;
  localparam logic [4:0] OP_JGT   = 5'd16;
  localparam logic [4:0] OP_QUIT  = 5'd17;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NUM  = 2'd1;
  localparam logic [1:0] KIND_CHR  = 2'd2;

  typedef struct packed {
    logic load;       // latch instruction
    logic pop_req;    // start memory read at head
    logic pop_take;   // take popped word into x or y
    logic take_y;
    logic div_start;
    logic finish;     // compute and register result
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic div_busy;
    logic [4:0] op;
    logic halted;
  } sts_t;
endpackage
`default_nettype wire

FILE: rtl/core/qmc_ram.sv
// generic single port write, single port registered read memory
`default_nettype none
module qmc_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/qmc_div.sv
// iterative unsigned 16-bit divider, one quotient bit per cycle
`default_nettype none
module qmc_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [qmc_pkg::WordW-1:0] dividend,
  input  wire logic [qmc_pkg::WordW-1:0] divisor,
  output logic                    busy,
  output logic [qmc_pkg::WordW-1:0] quotient,
  output logic [qmc_pkg::WordW-1:0] remainder
);
  import qmc_pkg::*;
  logic [WordW-1:0] dvs;
  logic [4:0] cnt;
  logic [WordW:0] trial;
  assign trial = {remainder, quotient[WordW-1]} - {1'b0, dvs};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 5'(WordW);
      quotient <= dividend;
      remainder <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[WordW]) begin
        remainder <= trial[WordW-1:0];
        quotient <= {quotient[WordW-2:0], 1'b1};
      end else begin
        remainder <= {remainder[WordW-2:0], quotient[WordW-1]};
        quotient <= {quotient[WordW-2:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/qmc_ctrl.sv
// controller state machine sequencing pops, division and result
`default_nettype none
module qmc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire qmc_pkg::sts_t  sts,
  output qmc_pkg::cmd_t       cmd
);
  import qmc_pkg::*;
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_DEC = 7'b0000010, S_RD = 7'b0000100,
    S_TAKE = 7'b0001000, S_DIV = 7'b0010000, S_FIN = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;
  state_t state, state_next;
  logic second, second_next;
  logic needs_pop, two_pops, is_div;
  always_comb begin
    needs_pop = !sts.halted && (sts.op == OP_ADD || sts.op == OP_SUB || sts.op == OP_MUL ||
      sts.op == OP_DIV || sts.op == OP_MOD || sts.op == OP_POPR || sts.op == OP_PRNP ||
      sts.op == OP_CHRP);
    two_pops = sts.op == OP_ADD || sts.op == OP_SUB || sts.op == OP_MUL ||
      sts.op == OP_DIV || sts.op == OP_MOD;
    is_div = !sts.halted && (sts.op == OP_DIV || sts.op == OP_MOD);
  end
  assign in_ready = state == S_IDLE || (state == S_OUT && out_ready);
  assign out_valid = state == S_OUT;
  always_comb begin
    state_next = state;
    second_next = second;
    cmd = '0;
    unique case (state)
      S_IDLE, S_OUT: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end else if (state == S_OUT && out_ready) begin
          state_next = S_IDLE;
        end
      end
      S_DEC: begin
        second_next = 1'b0;
        if (needs_pop) begin
          cmd.pop_req = 1'b1;
          state_next = S_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RD: state_next = S_TAKE;
      S_TAKE: begin
        cmd.pop_take = 1'b1;
        cmd.take_y = second;
        if (two_pops && !second) begin
          second_next = 1'b1;
          cmd.pop_req = 1'b1;
          state_next = S_RD;
        end else if (is_div) begin
          state_next = S_DIV;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!sts.div_busy) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      second <= 1'b0;
    end else begin
      state <= state_next;
      second <= second_next;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/qmc_dp.sv
// datapath: queue, register file, pc, arithmetic and result registers
`default_nettype none
module qmc_dp (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire qmc_pkg::cmd_t cmd,
  output qmc_pkg::sts_t   sts,
  input  wire logic [4:0] op,
  input  wire logic [15:0] literal,
  input  wire logic [4:0] reg_a,
  input  wire logic [4:0] reg_b,
  input  wire logic [11:0] target,
  output logic [1:0]      out_kind,
  output logic [15:0]     out_value,
  output logic [12:0]     next_pc,
  output logic            halted,
  output logic            queue_error
);
  import qmc_pkg::*;
  logic [4:0] i_op, i_ra, i_rb;
  logic [15:0] i_lit;
  logic [11:0] i_tgt;
  logic [QAW-1:0] head, tail;
  logic [QCW-1:0] count;
  logic [15:0] regs [RegCount];
  logic [PCW-1:0] pc;
  logic halt;
  logic err;
  logic [15:0] x, y, rdata, q, r;
  logic div_busy;
  logic push_we;
  logic [15:0] push_data, va, vb;
  logic [QAW-1:0] tail_inc, head_inc;
  logic [QAW-1:0] rd_addr, raddr;
  logic popped_empty;

  function automatic logic [15:0] x_in();
    return popped_empty ? '0 : rdata;
  endfunction

  // hold the read address until the popped word is taken
  assign raddr = cmd.pop_req ? head : rd_addr;

  qmc_ram #(.Width(WordW), .Depth(QueueDepth)) u_ram (
    .clk(clk), .we(push_we), .waddr(tail), .wdata(push_data), .raddr(raddr), .rdata(rdata)
  );
  qmc_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(x), .divisor(y),
    .busy(div_busy), .quotient(q), .remainder(r)
  );

  assign va = (i_ra < 5'(RegCount)) ? regs[i_ra] : '0;
  assign vb = (i_rb < 5'(RegCount)) ? regs[i_rb] : '0;
  assign tail_inc = (32'(tail) + 1 >= QueueDepth) ? '0 : tail + 1'b1;
  assign head_inc = (32'(head) + 1 >= QueueDepth) ? '0 : head + 1'b1;
  assign sts = '{empty: count == '0, div_busy: div_busy, op: i_op, halted: halt};

  logic do_push, jump, full;
  logic [31:0] npc;
  always_comb begin
    do_push = 1'b0;
    push_data = '0;
    jump = 1'b0;
    if (!halt) begin
      unique case (i_op)
        OP_PUSH: begin do_push = 1'b1; push_data = i_lit; end
        OP_ADD: begin do_push = 1'b1; push_data = x + y; end
        OP_SUB: begin do_push = 1'b1; push_data = x - y; end
        OP_MUL: begin do_push = 1'b1; push_data = 16'(x * y); end
        OP_DIV: begin do_push = 1'b1; push_data = (y == '0) ? '0 : q; end
        OP_MOD: begin do_push = 1'b1; push_data = (y == '0) ? '0 : r; end
        OP_PUSHR: begin do_push = 1'b1; push_data = va; end
        OP_JMP: jump = 1'b1;
        OP_JZ: jump = va == '0;
        OP_JEQ: jump = va == vb;
        OP_JGT: jump = va > vb;
        default: ;
      endcase
    end
    full = 32'(count) >= QueueDepth;
    push_we = cmd.finish && do_push && !full;
    if (i_op == OP_QUIT) npc = 32'(pc);
    else if (jump) npc = 32'(i_tgt);
    else npc = 32'(pc) + 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
      pc <= '0;
      halt <= 1'b0;
      for (int i = 0; i < RegCount; i++) regs[i] <= '0;
    end else begin
      if (cmd.pop_req && count != '0) begin
        head <= head_inc;
        count <= count - 1'b1;
      end
      if (push_we) begin
        tail <= tail_inc;
        count <= count + 1'b1;
      end
      if (cmd.pop_take && !cmd.take_y && i_op == OP_POPR && i_ra < 5'(RegCount))
        regs[i_ra] <= x_in();
      if (cmd.finish && !halt) begin
        if (i_op == OP_QUIT) begin
          halt <= 1'b1;
        end else if (npc >= ProgramDepth) begin
          halt <= 1'b1;
          pc <= PCW'(ProgramDepth);
        end else begin
          pc <= PCW'(npc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      i_op <= op; i_lit <= literal; i_ra <= reg_a; i_rb <= reg_b; i_tgt <= target;
      err <= 1'b0;
    end
    if (cmd.pop_req) begin
      rd_addr <= head;
      popped_empty <= count == '0;
      if (count == '0) err <= 1'b1;
    end
    if (cmd.pop_take) begin
      if (cmd.take_y) y <= x_in();
      else x <= x_in();
    end
    if (cmd.finish) begin
      out_kind <= KIND_NONE;
      out_value <= '0;
      if (!halt) begin
        if (i_op == OP_PRNP) begin out_kind <= KIND_NUM; out_value <= x; end
        if (i_op == OP_PRNR) begin out_kind <= KIND_NUM; out_value <= va; end
        if (i_op == OP_CHRP) begin out_kind <= KIND_CHR; out_value <= {8'd0, x[7:0]}; end
        if (i_op == OP_CHRR) begin out_kind <= KIND_CHR; out_value <= {8'd0, va[7:0]}; end
      end
      if (halt) begin
        next_pc <= pc;
        halted <= 1'b1;
        queue_error <= 1'b0;
      end else begin
        queue_error <= err || (do_push && full);
        if (i_op == OP_QUIT) begin
          next_pc <= pc; halted <= 1'b1;
        end else if (npc >= ProgramDepth) begin
          next_pc <= PCW'(ProgramDepth); halted <= 1'b1;
        end else begin
          next_pc <= PCW'(npc); halted <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/queue_machine_core.sv
// top level of the queue machine: one decoded instruction per transaction
//  channel | signals                                   | direction
//  in      | in_valid in_ready op literal reg_a reg_b target | input transaction
//  out     | out_valid out_ready out_kind out_value next_pc halted queue_error | result
// an instruction is decoded, pops its operands through the registered queue memory
// read, for divide or modulo waits on the bit-serial divider, and then registers
// its result; reset clears pointers, registers, pc and halt at once;
// a new transaction is taken in the cycle its predecessor's result is taken
`default_nettype none
module queue_machine_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  op,
  input  wire logic [15:0] literal,
  input  wire logic [4:0]  reg_a,
  input  wire logic [4:0]  reg_b,
  input  wire logic [11:0] target,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_value,
  output logic [12:0]      next_pc,
  output logic             halted,
  output logic             queue_error
);
  import qmc_pkg::*;
  cmd_t cmd;
  sts_t sts;
  qmc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );
  qmc_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .op(op), .literal(literal),
    .reg_a(reg_a), .reg_b(reg_b), .target(target), .out_kind(out_kind),
    .out_value(out_value), .next_pc(next_pc), .halted(halted), .queue_error(queue_error)
  );
endmodule
`default_nettype wire
